>>> hdl/bcbb_pkg.sv
// bcbb_pkg: shared types and constants of the border color bounding box block
// no dependencies; compiled first
`default_nettype none

package bcbb_pkg;

    localparam int unsigned CH_W      = 8;
    localparam int unsigned RGB_W     = 3 * CH_W;
    localparam int unsigned DIM_CFG_W = 13;
    localparam int unsigned POS_W     = 12;
    localparam int unsigned SIZE_W    = 13;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [DIM_CFG_W-1:0] DIM_RESET = 13'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [POS_W-1:0]  top_row;
        logic [POS_W-1:0]  bottom_row;
        logic [POS_W-1:0]  left_col;
        logic [POS_W-1:0]  right_col;
        logic [SIZE_W-1:0] crop_height;
        logic [SIZE_W-1:0] crop_width;
        logic              content_found;
    } box_result_t;

endpackage

`default_nettype wire

>>> hdl/bcbb_if.sv
// bcbb_if: valid/ready channel interfaces for pixels, box results and register writes
// depends on bcbb_pkg
`default_nettype none

interface bcbb_pix_if;
    import bcbb_pkg::*;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] pixel_red;
    logic [CH_W-1:0] pixel_green;
    logic [CH_W-1:0] pixel_blue;

    modport source (output valid, output pixel_red, output pixel_green, output pixel_blue,
                    input ready);
    modport sink   (input valid, input pixel_red, input pixel_green, input pixel_blue,
                    output ready);
endinterface

interface bcbb_box_if;
    import bcbb_pkg::*;
    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  top_row;
    logic [POS_W-1:0]  bottom_row;
    logic [POS_W-1:0]  left_col;
    logic [POS_W-1:0]  right_col;
    logic [SIZE_W-1:0] crop_height;
    logic [SIZE_W-1:0] crop_width;
    logic              content_found;

    modport source (output valid, output top_row, output bottom_row, output left_col,
                    output right_col, output crop_height, output crop_width,
                    output content_found, input ready);
    modport sink   (input valid, input top_row, input bottom_row, input left_col,
                    input right_col, input crop_height, input crop_width,
                    input content_found, output ready);
endinterface

interface bcbb_cfg_if;
    import bcbb_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_CFG_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/border_color_bounding_box_core.sv
// Auto-crop detector: pixels of a frame enter in raster order, one request per clock, and
// the first pixel of each frame sets the border color. One pixel is taken every cycle but
// for the stall below; a pixel passes an input register and then updates the box, so a
// frame's result is loaded into the result register when its last pixel leaves the input
// register. The only stall is the last pixel of a frame meeting an earlier result that has
// not yet been taken from the single result register.
// Top level; depends on bcbb_pkg, bcbb_if and bcbb_box
`default_nettype none

module border_color_bounding_box_core #(
    parameter int unsigned MAX_DIM = 4096
) (
    input  logic       clk,
    input  logic       rst_n,
    bcbb_pix_if.sink   pixel,
    bcbb_cfg_if.sink   cfg,
    bcbb_box_if.source box
);
    import bcbb_pkg::*;

    localparam int unsigned CW = $clog2(MAX_DIM);
    localparam int unsigned EW = (CW + 1 > DIM_CFG_W) ? CW + 1 : DIM_CFG_W;

    logic [DIM_CFG_W-1:0] width_reg, height_reg;
    logic [EW-1:0]        width_ext, height_ext, eff_w, eff_h;

    logic                 pix_valid_reg;
    logic [RGB_W-1:0]     rgb_reg;
    logic                 res_valid_reg;
    box_result_t          res_reg;
    box_result_t          res_next;
    logic                 frame_last;
    logic                 advance;

    // register writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (reg_idx_t'(cfg.index))
                REG_FRAME_WIDTH:  width_reg  <= cfg.data;
                REG_FRAME_HEIGHT: height_reg <= cfg.data;
                default:          ;
            endcase
        end
    end

    assign width_ext  = EW'(width_reg);
    assign height_ext = EW'(height_reg);
    assign eff_w = (width_reg == '0) ? EW'(1) :
                   (width_ext > EW'(MAX_DIM)) ? EW'(MAX_DIM) : width_ext;
    assign eff_h = (height_reg == '0) ? EW'(1) :
                   (height_ext > EW'(MAX_DIM)) ? EW'(MAX_DIM) : height_ext;

    // input register
    assign advance     = pix_valid_reg && !(frame_last && res_valid_reg && !box.ready);
    assign pixel.ready = !pix_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pix_valid_reg <= 1'b0;
        else if (pixel.ready)
            pix_valid_reg <= pixel.valid;
    end

    always_ff @(posedge clk)
    begin
        if (pixel.valid && pixel.ready)
            rgb_reg <= {pixel.pixel_red, pixel.pixel_green, pixel.pixel_blue};
    end

    bcbb_box #(
        .CW (CW),
        .EW (EW)
    ) u_box (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .rgb        (rgb_reg),
        .eff_w      (eff_w),
        .eff_h      (eff_h),
        .frame_last (frame_last),
        .result     (res_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance && frame_last)
            res_valid_reg <= 1'b1;
        else if (box.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && frame_last)
            res_reg <= res_next;
    end

    assign box.valid         = res_valid_reg;
    assign box.top_row       = res_reg.top_row;
    assign box.bottom_row    = res_reg.bottom_row;
    assign box.left_col      = res_reg.left_col;
    assign box.right_col     = res_reg.right_col;
    assign box.crop_height   = res_reg.crop_height;
    assign box.crop_width    = res_reg.crop_width;
    assign box.content_found = res_reg.content_found;

    a_res_from_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(advance && frame_last))
        else $error("result appeared without a frame end");

    a_pix_held: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid_reg && !advance |=> pix_valid_reg)
        else $error("stalled pixel dropped");

    a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
        box.valid && box.content_found |->
            box.top_row <= box.bottom_row && box.left_col <= box.right_col &&
            box.crop_height != '0 && box.crop_width != '0)
        else $error("inconsistent bounding box");

endmodule

`default_nettype wire

>>> hdl/bcbb_box.sv
// bcbb_box: raster position counters, border color latch and running bounding box
// depends on bcbb_pkg
`default_nettype none

module bcbb_box #(
    parameter int unsigned CW = 12,
    parameter int unsigned EW = 13
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [bcbb_pkg::RGB_W-1:0] rgb,
    input  logic [EW-1:0]              eff_w,
    input  logic [EW-1:0]              eff_h,
    output logic                       frame_last,
    output bcbb_pkg::box_result_t      result
);
    import bcbb_pkg::*;

    logic [CW-1:0]    col_reg, row_reg;
    logic [CW-1:0]    min_row_reg, max_row_reg, min_col_reg, max_col_reg;
    logic [RGB_W-1:0] border_reg;
    logic             found_reg;

    logic [CW-1:0]    min_row_next, max_row_next, min_col_next, max_col_next;
    logic             found_next;
    logic [RGB_W-1:0] border_next;
    logic             hit, col_end, row_end;
    logic [CW:0]      h_span, w_span;

    assign border_next = (col_reg == '0 && row_reg == '0) ? rgb : border_reg;
    assign hit         = rgb != border_next;
    assign col_end     = (EW'(col_reg) + EW'(1)) >= eff_w;
    assign row_end     = (EW'(row_reg) + EW'(1)) >= eff_h;
    assign frame_last  = col_end && row_end;

    always_comb
    begin
        min_row_next = min_row_reg;
        max_row_next = max_row_reg;
        min_col_next = min_col_reg;
        max_col_next = max_col_reg;
        found_next   = found_reg;
        if (hit)
        begin
            found_next   = 1'b1;
            max_row_next = row_reg;
            if (!found_reg)
            begin
                min_row_next = row_reg;
                min_col_next = col_reg;
                max_col_next = col_reg;
            end
            else
            begin
                if (col_reg < min_col_reg)
                    min_col_next = col_reg;
                if (col_reg > max_col_reg)
                    max_col_next = col_reg;
            end
        end
    end

    assign h_span = {1'b0, max_row_next} - {1'b0, min_row_next} + {{CW{1'b0}}, 1'b1};
    assign w_span = {1'b0, max_col_next} - {1'b0, min_col_next} + {{CW{1'b0}}, 1'b1};

    always_comb
    begin
        result = '0;
        if (found_next)
        begin
            result.top_row       = POS_W'(min_row_next);
            result.bottom_row    = POS_W'(max_row_next);
            result.left_col      = POS_W'(min_col_next);
            result.right_col     = POS_W'(max_col_next);
            result.crop_height   = SIZE_W'(h_span);
            result.crop_width    = SIZE_W'(w_span);
            result.content_found = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            border_reg  <= '0;
            min_row_reg <= '0;
            max_row_reg <= '0;
            min_col_reg <= '0;
            max_col_reg <= '0;
            found_reg   <= 1'b0;
        end
        else if (step)
        begin
            border_reg <= border_next;
            if (col_end)
            begin
                col_reg <= '0;
                row_reg <= row_end ? '0 : row_reg + CW'(1);
            end
            else
                col_reg <= col_reg + CW'(1);
            if (frame_last)
            begin
                min_row_reg <= '0;
                max_row_reg <= '0;
                min_col_reg <= '0;
                max_col_reg <= '0;
                found_reg   <= 1'b0;
            end
            else
            begin
                min_row_reg <= min_row_next;
                max_row_reg <= max_row_next;
                min_col_reg <= min_col_next;
                max_col_reg <= max_col_next;
                found_reg   <= found_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> sim/tb_border_color_bounding_box_core.sv
// tb_border_color_bounding_box_core: self-checking bench for the auto-crop box detector,
// predicts each frame's box from the pixels and register writes it sends, compares every result
// depends on bcbb_pkg, bcbb_if and border_color_bounding_box_core
`timescale 1ns / 100ps

module tb_border_color_bounding_box_core;
    import bcbb_pkg::*;

    logic clk;
    logic rst_n;

    bcbb_pix_if pix_ch ();
    bcbb_cfg_if cfg_ch ();
    bcbb_box_if box_ch ();

    border_color_bounding_box_core #(
        .MAX_DIM(4096)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .pixel(pix_ch),
        .cfg  (cfg_ch),
        .box  (box_ch)
    );

    // model of the detector
    int unsigned width_reg;
    int unsigned height_reg;
    int unsigned cur_col;
    int unsigned cur_row;
    logic [RGB_W-1:0] frame_border;
    int unsigned box_top;
    int unsigned box_bottom;
    int unsigned box_left;
    int unsigned box_right;
    bit box_seen;
    box_result_t expected_boxes[$];

    bit pix_idle = 1'b0;
    bit sink_idle = 1'b0;
    int hold_left = 0;
    int stall_left = 0;
    int error_count = 0;
    box_result_t got_box;
    box_result_t want_box;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned dim_limit(input int unsigned v);
        if (v == 0)
            return 1;
        if (v > 4096)
            return 4096;
        return v;
    endfunction

    function automatic void track_pixel(input logic [RGB_W-1:0] rgb);
        int unsigned w;
        int unsigned h;
        int unsigned crop_h;
        int unsigned crop_w;
        box_result_t res;
        w = dim_limit(width_reg);
        h = dim_limit(height_reg);
        if (cur_col == 0 && cur_row == 0)
            frame_border = rgb;
        if (rgb != frame_border)
        begin
            if (!box_seen)
            begin
                box_top = cur_row;
                box_bottom = cur_row;
                box_left = cur_col;
                box_right = cur_col;
                box_seen = 1'b1;
            end
            else
            begin
                box_bottom = cur_row;
                if (cur_col < box_left)
                    box_left = cur_col;
                if (cur_col > box_right)
                    box_right = cur_col;
            end
        end
        if (cur_col + 1 >= w)
        begin
            cur_col = 0;
            if (cur_row + 1 >= h)
            begin
                cur_row = 0;
                res = '0;
                if (box_seen)
                begin
                    crop_h = box_bottom - box_top + 1;
                    crop_w = box_right - box_left + 1;
                    res.top_row = box_top[POS_W-1:0];
                    res.bottom_row = box_bottom[POS_W-1:0];
                    res.left_col = box_left[POS_W-1:0];
                    res.right_col = box_right[POS_W-1:0];
                    res.crop_height = crop_h[SIZE_W-1:0];
                    res.crop_width = crop_w[SIZE_W-1:0];
                    res.content_found = 1'b1;
                end
                expected_boxes.push_back(res);
                box_seen = 1'b0;
                box_top = 0;
                box_bottom = 0;
                box_left = 0;
                box_right = 0;
            end
            else
                cur_row++;
        end
        else
            cur_col++;
    endfunction

    task automatic send_pixel(input logic [RGB_W-1:0] rgb);
        if (pix_idle && $urandom_range(0, 5) == 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pixel_red <= rgb[23:16];
        pix_ch.pixel_green <= rgb[15:8];
        pix_ch.pixel_blue <= rgb[7:0];
        @(posedge clk);
        while (pix_ch.ready !== 1'b1)
            @(posedge clk);
        track_pixel(rgb);
    endtask

    // stop offering pixels and let every pending box come out
    task automatic wait_idle();
        pix_ch.valid <= 1'b0;
        while (expected_boxes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_frame(input logic [DIM_CFG_W-1:0] w, input logic [DIM_CFG_W-1:0] h);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= REG_FRAME_WIDTH;
        cfg_ch.data <= w;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        width_reg = w;
        cfg_ch.index <= REG_FRAME_HEIGHT;
        cfg_ch.data <= h;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        height_reg = h;
        cfg_ch.valid <= 1'b0;
    endtask

    // random frames, some cut short and resized mid-frame
    task automatic run_frames(input int pixel_goal, input int dim_hi, input bit with_breaks,
                              input bit with_idle);
        int sent;
        int n;
        int stop_at;
        int density;
        bit hit;
        logic [DIM_CFG_W-1:0] w;
        logic [DIM_CFG_W-1:0] h;
        logic [RGB_W-1:0] border;
        logic [RGB_W-1:0] mask;
        sent = 0;
        while (sent < pixel_goal)
        begin
            w = DIM_CFG_W'(($urandom_range(0, 9) < 7) ? $urandom_range(1, 6)
                                                       : $urandom_range(0, dim_hi));
            h = DIM_CFG_W'(($urandom_range(0, 9) < 7) ? $urandom_range(1, 6)
                                                       : $urandom_range(0, 8));
            set_frame(w, h);
            if (with_idle)
            begin
                pix_idle = ($urandom_range(0, 3) != 0);
                sink_idle = ($urandom_range(0, 3) != 0);
            end
            border = RGB_W'($urandom);
            density = $urandom_range(0, 3);
            stop_at = (with_breaks && $urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : -1;
            n = 0;
            do
            begin
                case (density)
                    0: hit = 1'b0;
                    1: hit = ($urandom_range(0, 15) == 0);
                    2: hit = ($urandom_range(0, 1) == 0);
                    default: hit = 1'b1;
                endcase
                mask = 24'd0;
                if (hit)
                    mask = $urandom_range(0, 1) ? (24'd1 << $urandom_range(0, 23))
                                                : 24'($urandom_range(1, 24'hFFFFFF));
                send_pixel((cur_col == 0 && cur_row == 0) ? border : border ^ mask);
                n++;
                sent++;
            end
            while ((cur_col != 0 || cur_row != 0) && n != stop_at);
        end
    endtask

    task automatic test_directed();
        // one pixel of content in a 3x2 frame, then a frame with no content
        set_frame(13'd3, 13'd2);
        send_pixel(24'h000000);
        send_pixel(24'h000000);
        send_pixel(24'h000000);
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h000000);
        repeat (6) send_pixel(24'hFFFFFF);
        // zero size counts as one
        set_frame(13'd0, 13'd0);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h123456);
        // single channel differences
        set_frame(13'd2, 13'd2);
        send_pixel(24'h808080);
        send_pixel(24'h807F80);
        send_pixel(24'h008080);
        send_pixel(24'h808081);
        // frame shrunk part way through
        set_frame(13'd4, 13'd4);
        send_pixel(24'h00FF00);
        send_pixel(24'h00FF00);
        send_pixel(24'h00FF00);
        send_pixel(24'h00FF00);
        send_pixel(24'h00FF00);
        send_pixel(24'hFF0000);
        set_frame(13'd2, 13'd2);
        send_pixel(24'h0000FF);
    endtask

    task automatic test_large_frames();
        logic [RGB_W-1:0] border;
        int i;
        pix_idle = 1'b0;
        sink_idle = 1'b0;
        border = RGB_W'($urandom);
        // oversize width, row then cut short by a narrow width
        set_frame(13'h1FFF, 13'd1);
        for (i = 0; i < 20; i++)
            send_pixel((i == 1 || i == 13) ? ~border : border);
        set_frame(13'd3, 13'd1);
        send_pixel(border);
        // oversize height on one-pixel rows, then cut short
        set_frame(13'd1, 13'h1FFF);
        for (i = 0; i < 12; i++)
            send_pixel((i == 7) ? border ^ 24'h000001 : border);
        set_frame(13'd1, 13'd2);
        send_pixel(border);
    endtask

    task automatic test_random_frames();
        run_frames(600, 40, 1'b1, 1'b1);
    endtask

    task automatic test_result_backpressure();
        int i;
        pix_idle = 1'b0;
        set_frame(13'd2, 13'd1);
        hold_left = 250;
        for (i = 0; i < 64; i++)
            send_pixel(($urandom_range(0, 2) == 0) ? 24'($urandom) : 24'h00FF00);
    endtask

    task automatic test_no_idle();
        pix_idle = 1'b0;
        sink_idle = 1'b0;
        run_frames(150, 5, 1'b0, 1'b0);
    endtask

    initial
    begin : box_ready_drive
        box_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                box_ch.ready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else if (stall_left > 0)
            begin
                box_ch.ready <= 1'b0;
                stall_left = stall_left - 1;
            end
            else if (sink_idle && $urandom_range(0, 5) == 0)
            begin
                box_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 7);
            end
            else
                box_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (box_ch.valid === 1'b1 && box_ch.ready === 1'b1)
        begin
            got_box.top_row = box_ch.top_row;
            got_box.bottom_row = box_ch.bottom_row;
            got_box.left_col = box_ch.left_col;
            got_box.right_col = box_ch.right_col;
            got_box.crop_height = box_ch.crop_height;
            got_box.crop_width = box_ch.crop_width;
            got_box.content_found = box_ch.content_found;
            if (expected_boxes.size() == 0)
            begin
                if (error_count < 10)
                    $display("%0t: box result with none expected: top %0d bottom %0d",
                             $realtime, got_box.top_row, got_box.bottom_row);
                error_count++;
            end
            else
            begin
                want_box = expected_boxes.pop_front();
                if (got_box.top_row !== want_box.top_row
                        || got_box.bottom_row !== want_box.bottom_row
                        || got_box.left_col !== want_box.left_col
                        || got_box.right_col !== want_box.right_col
                        || got_box.crop_height !== want_box.crop_height
                        || got_box.crop_width !== want_box.crop_width
                        || got_box.content_found !== want_box.content_found)
                begin
                    if (error_count < 10)
                    begin
                        $display("%0t: expected t %0d b %0d l %0d r %0d h %0d w %0d f %0d",
                                 $realtime, want_box.top_row, want_box.bottom_row,
                                 want_box.left_col, want_box.right_col, want_box.crop_height,
                                 want_box.crop_width, want_box.content_found);
                        $display("%0t: actual   t %0d b %0d l %0d r %0d h %0d w %0d f %0d",
                                 $realtime, got_box.top_row, got_box.bottom_row,
                                 got_box.left_col, got_box.right_col, got_box.crop_height,
                                 got_box.crop_width, got_box.content_found);
                    end
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        width_reg = DIM_RESET;
        height_reg = DIM_RESET;
        cur_col = 0;
        cur_row = 0;
        frame_border = '0;
        box_top = 0;
        box_bottom = 0;
        box_left = 0;
        box_right = 0;
        box_seen = 1'b0;
        rst_n <= 1'b0;
        pix_ch.valid <= 1'b0;
        pix_ch.pixel_red <= '0;
        pix_ch.pixel_green <= '0;
        pix_ch.pixel_blue <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_FRAME_WIDTH;
        cfg_ch.data <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_large_frames();
        test_random_frames();
        test_result_backpressure();
        test_no_idle();

        wait_idle();
        repeat (8) @(posedge clk);
        error_count += expected_boxes.size();
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
hdl/bcbb_pkg.sv
hdl/bcbb_if.sv
hdl/bcbb_box.sv
hdl/border_color_bounding_box_core.sv
sim/tb_border_color_bounding_box_core.sv
